>>> sv/pfv_pkg.sv
// Shared types, constants and the base table for the prime factor verifier.
package pfv_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned K_W     = 32;
  localparam int unsigned N_W     = 32;
  localparam int unsigned SIGN_W  = 2;
  localparam int unsigned VERD_W  = 2;
  localparam int unsigned BASE_W  = 32;
  localparam int unsigned NUM_BASES = 7;
  localparam int unsigned BIDX_W  = $clog2(NUM_BASES);
  localparam int unsigned CNT_W   = $clog2(WORD_W + 1);
  localparam int unsigned TWOS_W  = $clog2(WORD_W);

  // verdict codes
  localparam logic [VERD_W-1:0] VERDICT_COMPOSITE = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_PRIME     = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_FACTOR    = 2'd2;

  // sign codes (two's complement)
  localparam logic [SIGN_W-1:0] SIGN_PLUS  = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_MINUS = 2'b11;

  // addend select of the modular multiplier
  typedef enum logic [1:0] {
    ASEL_X   = 2'd0,
    ASEL_B   = 2'd1,
    ASEL_KM  = 2'd2,
    ASEL_ONE = 2'd3
  } pfv_asel_t;

  // multiplier-bit source select
  typedef enum logic [1:0] {
    MSEL_X    = 2'd0,
    MSEL_BASE = 2'd1,
    MSEL_K    = 2'd2
  } pfv_msel_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              shift_d;
    logic              mul_start;
    pfv_asel_t         a_sel;
    pfv_msel_t         m_sel;
    logic [BIDX_W-1:0] base_idx;
    logic              copy_b;
    logic              copy_km;
    logic              set_b2;
    logic              set_pow;
    logic              set_pow_n;
    logic              e_shift;
    logic              s_dec;
  } pfv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic p_bad;
    logic d_odd;
    logic mul_busy;
    logic x_zero;
    logic x_one;
    logic x_pm1;
    logic e_top;
    logic e_done;
    logic s_last;
    logic factor;
  } pfv_status_t;

  // fixed witness bases
  function automatic logic [BASE_W-1:0] base_value(input logic [BIDX_W-1:0] idx);
    logic [BASE_W-1:0] v;
    unique case (idx)
      3'd0:    v = 32'd2;
      3'd1:    v = 32'd325;
      3'd2:    v = 32'd9375;
      3'd3:    v = 32'd28178;
      3'd4:    v = 32'd450775;
      3'd5:    v = 32'd9780504;
      3'd6:    v = 32'd1795265022;
      default: v = 32'd2;
    endcase
    return v;
  endfunction

endpackage

>>> sv/prime_factor_verifier.sv
// Top level of the prime factor verifier.
//
//   channel | direction | payload                                   | handshake
//   in      | to block  | candidate, multiplier, exponent, sign     | in_valid / in_ready
//   out     | from block| verdict                                   | out_valid / out_ready
//
// One word at a time. Each modular product runs on the shared bit-serial multiplier
// (a start and 64 steps); each base costs one reduction and up to about 126 squarings
// and multiplies. An even candidate or 1 skips the multiplier and goes from the
// candidate check straight to the output handshake.
// Reset (rst, synchronous) returns the controller to idle and drops out_valid.
// A result waiting on out_ready does not block the next input word; a second result
// waits in the controller until the output register is free.
module prime_factor_verifier (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pfv_pkg::WORD_W-1:0]  candidate,
  input  logic [pfv_pkg::K_W-1:0]     multiplier,
  input  logic [pfv_pkg::N_W-1:0]     exponent,
  input  logic [pfv_pkg::SIGN_W-1:0]  sign,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pfv_pkg::VERD_W-1:0]  verdict
);
  import pfv_pkg::*;

  pfv_cmd_t    cmd;
  pfv_status_t st;

  pfv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict),
    .st        (st),
    .cmd       (cmd)
  );

  pfv_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .candidate  (candidate),
    .multiplier (multiplier),
    .exponent   (exponent),
    .sign       (sign),
    .st         (st)
  );

endmodule

>>> sv/pfv_dp.sv
// Datapath: operand registers, bit-serial modular multiplier, counters.
module pfv_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  pfv_pkg::pfv_cmd_t         cmd,
  input  logic [pfv_pkg::WORD_W-1:0] candidate,
  input  logic [pfv_pkg::K_W-1:0]    multiplier,
  input  logic [pfv_pkg::N_W-1:0]    exponent,
  input  logic [pfv_pkg::SIGN_W-1:0] sign,
  output pfv_pkg::pfv_status_t      st
);
  import pfv_pkg::*;

  logic [WORD_W-1:0] p, x, b, km, d, e;
  logic [K_W-1:0]    k;
  logic [N_W-1:0]    n;
  logic [SIGN_W-1:0] sgn;
  logic [TWOS_W-1:0] twos, scnt;
  logic [CNT_W-1:0]  ecnt;

  // multiplier state
  logic [WORD_W-1:0] mr, ma, mb;
  logic [CNT_W-1:0]  mcnt;
  logic              mbusy;

  logic [WORD_W-1:0] a_in, m_in, mr_next;
  logic [WORD_W+1:0] t;
  logic [WORD_W+2:0] u1, u2;

  // operand selection at start
  always_comb begin
    unique case (cmd.a_sel)
      ASEL_X:   a_in = x;
      ASEL_B:   a_in = b;
      ASEL_KM:  a_in = km;
      ASEL_ONE: a_in = WORD_W'(1);
      default:  a_in = x;
    endcase
    unique case (cmd.m_sel)
      MSEL_X:    m_in = x;
      MSEL_BASE: m_in = WORD_W'(base_value(cmd.base_idx));
      MSEL_K:    m_in = WORD_W'(k);
      default:   m_in = x;
    endcase
  end

  // one step: r = (2r + bit*a) mod p, sum below 3p
  always_comb begin
    t  = {1'b0, mr, 1'b0} + {2'b00, (mb[WORD_W-1] ? ma : '0)};
    u1 = {1'b0, t} - {3'b000, p};
    u2 = {1'b0, t} - {2'b00, p, 1'b0};
    priority if (!u2[WORD_W+2]) mr_next = u2[WORD_W-1:0];
    else if (!u1[WORD_W+2])     mr_next = u1[WORD_W-1:0];
    else                        mr_next = t[WORD_W-1:0];
  end

  // multiplier control
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mcnt  <= '0;
    end else if (cmd.mul_start) begin
      mbusy <= 1'b1;
      mcnt  <= CNT_W'(WORD_W);
    end else if (mbusy) begin
      mcnt <= mcnt - 1'b1;
      if (mcnt == CNT_W'(1)) mbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mr <= '0;
      ma <= a_in;
      mb <= m_in;
    end else if (mbusy) begin
      mr <= mr_next;
      mb <= {mb[WORD_W-2:0], 1'b0};
    end
  end

  // operand and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p    <= candidate;
      k    <= multiplier;
      n    <= exponent;
      sgn  <= sign;
      d    <= candidate - 1'b1;
      twos <= '0;
    end
    if (cmd.shift_d) begin
      d    <= {1'b0, d[WORD_W-1:1]};
      twos <= twos + 1'b1;
    end
    if (cmd.copy_b)  b  <= x;
    if (cmd.copy_km) km <= x;
    if (cmd.set_b2)  b  <= WORD_W'(2);
    if (mbusy && mcnt == CNT_W'(1)) x <= mr_next;
    if (cmd.set_pow) begin
      x    <= WORD_W'(1);
      e    <= d;
      ecnt <= CNT_W'(WORD_W);
      scnt <= twos;
    end
    if (cmd.set_pow_n) begin
      x    <= WORD_W'(1);
      e    <= WORD_W'(n);
      ecnt <= CNT_W'(WORD_W);
    end
    if (cmd.e_shift) begin
      e    <= {e[WORD_W-2:0], 1'b0};
      ecnt <= ecnt - 1'b1;
    end
    if (cmd.s_dec) scnt <= scnt - 1'b1;
  end

  // status
  always_comb begin
    st.p_bad    = !p[0] || (p == WORD_W'(1));
    st.d_odd    = d[0];
    st.mul_busy = mbusy;
    st.x_zero   = (x == '0);
    st.x_one    = (x == WORD_W'(1));
    st.x_pm1    = (x == p - 1'b1);
    st.e_top    = e[WORD_W-1];
    st.e_done   = (ecnt == '0);
    st.s_last   = (scnt <= TWOS_W'(1));
    st.factor   = ((x == WORD_W'(1)) && (sgn == SIGN_MINUS)) ||
                  ((x == p - 1'b1) && (sgn == SIGN_PLUS));
  end

endmodule

>>> sv/pfv_ctrl.sv
// Controller: sequences the primality test and the residue check.
module pfv_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pfv_pkg::VERD_W-1:0]  verdict,
  input  pfv_pkg::pfv_status_t        st,
  output pfv_pkg::pfv_cmd_t           cmd
);
  import pfv_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_CHKP  = 17'h00002,
    S_SHD   = 17'h00004,
    S_BRED  = 17'h00008,
    S_BRW   = 17'h00010,
    S_BCHK  = 17'h00020,
    S_PSTEP = 17'h00040,
    S_PSQ   = 17'h00080,
    S_PMW   = 17'h00100,
    S_CHK0  = 17'h00200,
    S_SLOOP = 17'h00400,
    S_SWAIT = 17'h00800,
    S_PASS  = 17'h01000,
    S_KRW   = 17'h02000,
    S_KCP   = 17'h04000,
    S_KMW   = 17'h08000,
    S_FIN   = 17'h10000
  } pfv_state_t;

  pfv_state_t        state, state_next;
  logic [BIDX_W-1:0] bidx, bidx_next;
  logic              fin_ph, fin_ph_next;
  logic [VERD_W-1:0] res, res_next;
  logic              out_valid_next;
  logic [VERD_W-1:0] verdict_next;

  // next state and commands
  always_comb begin
    state_next     = state;
    bidx_next      = bidx;
    fin_ph_next    = fin_ph;
    res_next       = res;
    out_valid_next = out_valid && !out_ready;
    verdict_next   = verdict;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.a_sel      = ASEL_X;
    cmd.m_sel      = MSEL_X;
    cmd.base_idx   = bidx;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          bidx_next   = '0;
          fin_ph_next = 1'b0;
          state_next  = S_CHKP;
        end
      end
      S_CHKP: begin
        if (st.p_bad) begin
          res_next   = VERDICT_COMPOSITE;
          state_next = S_FIN;
        end else begin
          state_next = S_SHD;
        end
      end
      S_SHD: begin
        if (st.d_odd) state_next = S_BRED;
        else          cmd.shift_d = 1'b1;
      end
      // reduce the witness base mod p
      S_BRED: begin
        cmd.mul_start = 1'b1;
        cmd.a_sel     = ASEL_ONE;
        cmd.m_sel     = MSEL_BASE;
        state_next    = S_BRW;
      end
      S_BRW: if (!st.mul_busy) state_next = S_BCHK;
      S_BCHK: begin
        cmd.copy_b  = 1'b1;
        cmd.set_pow = 1'b1;
        state_next  = st.x_zero ? S_PASS : S_PSTEP;
      end
      // left-to-right exponentiation, leading zeros skipped
      S_PSTEP: begin
        if (st.e_done) begin
          state_next = S_CHK0;
        end else if (!st.e_top && st.x_one) begin
          cmd.e_shift = 1'b1;
        end else begin
          cmd.mul_start = 1'b1;
          state_next    = S_PSQ;
        end
      end
      S_PSQ: begin
        if (!st.mul_busy) begin
          if (st.e_top) begin
            cmd.mul_start = 1'b1;
            cmd.a_sel     = ASEL_B;
            state_next    = S_PMW;
          end else begin
            cmd.e_shift = 1'b1;
            state_next  = S_PSTEP;
          end
        end
      end
      S_PMW: begin
        if (!st.mul_busy) begin
          cmd.e_shift = 1'b1;
          state_next  = S_PSTEP;
        end
      end
      S_CHK0: begin
        if (fin_ph) begin
          cmd.mul_start = 1'b1;
          cmd.a_sel     = ASEL_KM;
          state_next    = S_KMW;
        end else if (st.x_one || st.x_pm1) begin
          state_next = S_PASS;
        end else begin
          state_next = S_SLOOP;
        end
      end
      // repeated squarings looking for p-1
      S_SLOOP: begin
        if (st.s_last) begin
          res_next   = VERDICT_COMPOSITE;
          state_next = S_FIN;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.s_dec     = 1'b1;
          state_next    = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (!st.mul_busy) state_next = st.x_pm1 ? S_PASS : S_SLOOP;
      end
      S_PASS: begin
        if (bidx == BIDX_W'(NUM_BASES - 1)) begin
          cmd.mul_start = 1'b1;
          cmd.a_sel     = ASEL_ONE;
          cmd.m_sel     = MSEL_K;
          state_next    = S_KRW;
        end else begin
          bidx_next  = bidx + 1'b1;
          state_next = S_BRED;
        end
      end
      S_KRW: if (!st.mul_busy) state_next = S_KCP;
      S_KCP: begin
        cmd.copy_km   = 1'b1;
        cmd.set_b2    = 1'b1;
        cmd.set_pow_n = 1'b1;
        fin_ph_next   = 1'b1;
        state_next    = S_PSTEP;
      end
      S_KMW: begin
        if (!st.mul_busy) begin
          res_next   = st.factor ? VERDICT_FACTOR : VERDICT_PRIME;
          state_next = S_FIN;
        end
      end
      // hand the word to the output register
      S_FIN: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          verdict_next   = res;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bidx      <= '0;
      fin_ph    <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      bidx      <= bidx_next;
      fin_ph    <= fin_ph_next;
    end
  end

  always_ff @(posedge clk) begin
    res     <= res_next;
    verdict <= verdict_next;
  end

endmodule

>>> sv/pfv_checker.sv
// Port-level checks for the prime factor verifier, bound to the top level.
module pfv_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [pfv_pkg::WORD_W-1:0]  candidate,
  input logic [pfv_pkg::K_W-1:0]     multiplier,
  input logic [pfv_pkg::N_W-1:0]     exponent,
  input logic [pfv_pkg::SIGN_W-1:0]  sign,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pfv_pkg::VERD_W-1:0]  verdict
);
  import pfv_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("result changed while stalled");

  // only defined verdict codes
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == VERDICT_COMPOSITE || verdict == VERDICT_PRIME ||
                   verdict == VERDICT_FACTOR))
    else $error("undefined verdict code");

  // one word in flight: busy right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second word while busy");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind prime_factor_verifier pfv_checker u_pfv_checker (.*);

>>> dv/pfv_verdict_checker.sv
// Checker for the prime factor verifier: predicts each verdict and compares it on the output.
`timescale 1ns / 100ps

module pfv_verdict_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [pfv_pkg::WORD_W-1:0] candidate,
  input  logic [pfv_pkg::K_W-1:0]    multiplier,
  input  logic [pfv_pkg::N_W-1:0]    exponent,
  input  logic [pfv_pkg::SIGN_W-1:0] sign,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [pfv_pkg::VERD_W-1:0] verdict,
  output int                         failures,
  output int                         pending
);
  import pfv_pkg::*;

  logic [VERD_W-1:0] expected_verdicts[$];

  // (a * b) mod m on a double-width product
  function automatic logic [63:0] mod_product(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, m});
  endfunction

  // b^e mod m, m >= 2
  function automatic logic [63:0] mod_power(input logic [63:0] b, input logic [63:0] e,
                                            input logic [63:0] m);
    logic [63:0] r;
    r = 64'd1 % m;
    for (int i = 63; i >= 0; i--) begin
      r = mod_product(r, r, m);
      if (e[i]) r = mod_product(r, b, m);
    end
    return r;
  endfunction

  // strong probable prime test of odd p >= 3 to base b
  function automatic bit passes_witness(input logic [63:0] b, input logic [63:0] p);
    logic [63:0] d;
    logic [63:0] x;
    int          twos;
    d    = p - 64'd1;
    twos = 0;
    while (!d[0]) begin
      d = d >> 1;
      twos++;
    end
    x = mod_power(b, d, p);
    if (x == 64'd1 || x == p - 64'd1) return 1'b1;
    for (int s = 1; s < twos; s++) begin
      x = mod_product(x, x, p);
      if (x == p - 64'd1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_prime(input logic [63:0] p);
    logic [63:0] witnesses[NUM_BASES];
    logic [63:0] b;
    witnesses = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
                  64'd1795265022};
    if (!p[0] || p == 64'd1) return 1'b0;
    foreach (witnesses[i]) begin
      b = witnesses[i] % p;
      // a base that is a multiple of p says nothing
      if (b != 64'd0 && !passes_witness(b, p)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [VERD_W-1:0] predict_verdict(
      input logic [63:0] p, input logic [K_W-1:0] k, input logic [N_W-1:0] n,
      input logic [SIGN_W-1:0] c);
    logic [63:0] a;
    if (!is_prime(p)) return VERDICT_COMPOSITE;
    a = mod_power(64'd2 % p, {32'd0, n}, p);
    a = mod_product(a, {32'd0, k} % p, p);
    if ((a == 64'd1 && c == SIGN_MINUS) || (a == p - 64'd1 && c == SIGN_PLUS))
      return VERDICT_FACTOR;
    return VERDICT_PRIME;
  endfunction

  initial begin
    failures = 0;
    pending  = 0;
  end

  // predict on input words, compare on output words
  always @(posedge clk) begin
    logic [VERD_W-1:0] want;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_verdicts.push_back(predict_verdict(candidate, multiplier, exponent, sign));
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          failures++;
          if (failures <= 10) $display("unexpected verdict %0d with none pending", verdict);
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict !== want) begin
            failures++;
            if (failures <= 10)
              $display("verdict mismatch: expected %0d actual %0d", want, verdict);
          end
        end
      end
      pending = expected_verdicts.size();
    end
  end

endmodule

>>> dv/tb_prime_factor_verifier.sv
// Testbench top for the prime factor verifier: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_prime_factor_verifier;
  import pfv_pkg::*;

  localparam logic [SIGN_W-1:0] SIGN_ZERO     = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_MINUS2   = 2'b10;
  localparam int                RANDOM_WORDS  = 300;
  localparam int                STALL_LIMIT   = 400000;
  localparam int                HOLD_CYCLES   = 400;
  localparam int                HOLD_AT       = 150;
  localparam int                DRAIN_AT      = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [WORD_W-1:0] candidate = '0;
  logic [K_W-1:0]    multiplier = '0;
  logic [N_W-1:0]    exponent = '0;
  logic [SIGN_W-1:0] sign = SIGN_PLUS;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [VERD_W-1:0] verdict;
  int                failures;
  int                pending;
  int                sent = 0;
  int                idle_cycles = 0;
  bit                hold_request = 1'b0;

  logic [63:0] known_primes[14] = '{64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd19, 64'd73,
    64'd193, 64'd65537, 64'd1000000007, 64'd998244353, 64'd4294967291,
    64'd2305843009213693951, 64'd18446744073709551557};

  always #5 clk = ~clk;

  prime_factor_verifier i_dut (.*);

  pfv_verdict_checker i_checker (.*);

  // 2^-n mod p for a prime p below 2^32
  function automatic logic [63:0] inverse_power_of_two(input logic [63:0] p,
                                                       input logic [N_W-1:0] n);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] e;
    r = 64'd1;
    b = 64'd2 % p;
    e = (p - 64'd1) - ({32'd0, n} % (p - 64'd1));
    while (e != 64'd0) begin
      if (e[0]) r = (r * b) % p;
      b = (b * b) % p;
      e = e >> 1;
    end
    return r;
  endfunction

  task automatic send_word(input logic [63:0] p, input logic [K_W-1:0] k,
                           input logic [N_W-1:0] n, input logic [SIGN_W-1:0] c);
    int gap;
    gap = $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    candidate  = p;
    multiplier = k;
    exponent   = n;
    sign       = c;
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  // receiver: random stall per word, one long hold-off on request
  initial begin
    int  gap;
    bit  held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request && !held) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // watchdog on cycles without any accepted word or taken result
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [63:0]       p;
    logic [K_W-1:0]    k;
    logic [N_W-1:0]    n;
    logic [SIGN_W-1:0] c;
    int                pick;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: even and unit candidates
    send_word(64'd0, 32'd1, 32'd1, SIGN_MINUS);
    send_word(64'd1, 32'd0, 32'd0, SIGN_PLUS);
    send_word(64'd2, 32'd1, 32'd1, SIGN_PLUS);
    send_word(64'hFFFF_FFFF_FFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIGN_MINUS);
    // odd composites, including strong pseudoprimes to some bases
    send_word(64'd9, 32'd1, 32'd3, SIGN_MINUS);
    send_word(64'd561, 32'd5, 32'd7, SIGN_PLUS);
    send_word(64'd2047, 32'd1, 32'd11, SIGN_MINUS);
    send_word(64'd3215031751, 32'd3, 32'd9, SIGN_PLUS);
    send_word(64'd3825123056546413051, 32'd7, 32'd100, SIGN_MINUS);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0, SIGN_PLUS);
    // small primes that divide a base
    send_word(64'd3, 32'd1, 32'd1, SIGN_PLUS);
    send_word(64'd5, 32'd1, 32'd2, SIGN_PLUS);
    send_word(64'd73, 32'd0, 32'hFFFF_FFFF, SIGN_MINUS);
    // large primes, factor forms, zero exponent, signs other than plus or minus one
    send_word(64'd2305843009213693951, 32'd1, 32'd61, SIGN_MINUS);
    send_word(64'd998244353, 32'd119, 32'd23, SIGN_PLUS);
    send_word(64'd18446744073709551557, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIGN_PLUS);
    send_word(64'd4294967291, 32'd1, 32'd0, SIGN_MINUS);
    send_word(64'd13, 32'd1, 32'd12, SIGN_ZERO);
    send_word(64'd13, 32'd1, 32'd12, SIGN_MINUS2);

    // random part: mostly cheap even candidates, some odd ones, a few primes
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == DRAIN_AT) begin
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if (i == HOLD_AT) hold_request = 1'b1;
      p    = {$urandom, $urandom};
      k    = $urandom;
      n    = ($urandom_range(0, 3) == 0) ? N_W'($urandom_range(0, 70)) : N_W'($urandom);
      c    = SIGN_W'($urandom_range(0, 3));
      pick = (i >= HOLD_AT && i < HOLD_AT + 20) ? 0 : $urandom_range(0, 99);
      if (pick < 80) begin
        p[0] = 1'b0;
      end else if (pick < 95) begin
        p[0] = 1'b1;
      end else begin
        p = known_primes[$urandom_range(0, 13)];
        c = $urandom_range(0, 1) ? SIGN_PLUS : SIGN_MINUS;
        // most of the time build a true factor when k can reach the residue
        if (p < 64'h1_0000_0000 && $urandom_range(0, 3) != 0) begin
          k = K_W'(inverse_power_of_two(p, n));
          if (c == SIGN_PLUS) k = K_W'(p - {32'd0, k});
        end
      end
      send_word(p, k, n, c);
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/pfv_pkg.sv
sv/pfv_dp.sv
sv/pfv_ctrl.sv
sv/prime_factor_verifier.sv
sv/pfv_checker.sv
dv/pfv_verdict_checker.sv
dv/tb_prime_factor_verifier.sv
